### rtl/ocpc_pkg.sv
`default_nettype none

package ocpc_pkg;

   // Function codes carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_MASK      = 2'd0,
      FUNC_DRAW      = 2'd1,
      FUNC_LETTERBOX = 2'd2
   } func_type;

   // Register indexes on the csr channel
   typedef enum logic [2:0] {
      CSR_CROP_LEFT    = 3'd0,
      CSR_CROP_RIGHT   = 3'd1,
      CSR_CROP_TOP     = 3'd2,
      CSR_CROP_BOTTOM  = 3'd3,
      CSR_COLOR_BLACK  = 3'd4,
      CSR_COLOR_BORDER = 3'd5,
      CSR_COLOR_BG     = 3'd6
   } csr_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned PIXEL_WIDTH     = 8;
   localparam int unsigned COLOR_WIDTH     = 7;

   // Mirror flag marking a cropmark pixel
   localparam logic [PIXEL_WIDTH-1:0] MIRROR_FLAG = 8'h80;
   // Screen values that a flagged mirror pixel may overwrite
   localparam logic [PIXEL_WIDTH-1:0] PIX_BLANK   = 8'h00;
   localparam logic [PIXEL_WIDTH-1:0] PIX_GRAY    = 8'h14;
   localparam logic [PIXEL_WIDTH-1:0] PIX_DARK    = 8'h03;

   localparam logic [COLOR_WIDTH-1:0] RESET_BLACK  = 7'd2;
   localparam logic [COLOR_WIDTH-1:0] RESET_BORDER = 7'd60;
   localparam logic [COLOR_WIDTH-1:0] RESET_BG     = 7'd20;

   localparam int RESET_LEFT   = 0;
   localparam int RESET_RIGHT  = 719;
   localparam int RESET_TOP    = 0;
   localparam int RESET_BOTTOM = 479;

endpackage

`default_nettype wire

### rtl/overlay_cropmark_pixel_compositor.sv
`default_nettype none

// Cropmark overlay compositor. One beat in, one beat out: each req beat is a
// pixel (coordinate, screen byte, mirror byte, function in tuser) and each rsp
// beat gives the new screen and mirror bytes with their write enables. The
// block takes one pixel per clock unless rsp stalls; it passes an input
// register, the compare and select logic and a result register. Ready on
// the req side falls only when both registers are full and rsp is stalled.
// Crop edges and colors are written over the csr channel, which is always
// ready; write them only while no pixel is in flight. A coordinate of
// COORD_WIDTH bits is compared against the crop edges with two guard bits,
// so the one-pixel border band never wraps.
module overlay_cropmark_pixel_compositor
   import ocpc_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 11
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [CW-1:0] pixel_x, [2CW-1:CW] pixel_y, [+7:2CW] screen_in,
   // [+15:2CW+8] mirror_in, zero pad to whole bytes
   input  wire logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]                         req_tuser,
   // result stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] screen_out, [8] screen_we, [16:9] mirror_out, [17] mirror_we,
   // [23:18] zero
   output      logic [23:0]                        rsp_tdata,
   // register write channel
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]         csr_index,
   input  wire logic [COORD_WIDTH-1:0]             csr_data
);

   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned RW = CW + 1;  // crop edge storage, holds reset edges
   localparam int unsigned EW = CW + 2;  // compare width with guard bits
   localparam logic signed [EW-1:0] TWO = EW'(2);

   // ---------------- configuration ----------------
   logic signed [RW-1:0]   crop_left_ff, crop_right_ff, crop_top_ff, crop_bottom_ff;
   logic signed [RW-1:0]   crop_left_in, crop_right_in, crop_top_in, crop_bottom_in;
   logic [COLOR_WIDTH-1:0] black_ff, border_ff, bg_ff;
   logic [COLOR_WIDTH-1:0] black_in, border_in, bg_in;
   logic                   csr_fire;
   logic signed [RW-1:0]   csr_coord;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_coord = signed'({csr_data[CW-1], csr_data});

   always_comb begin
      crop_left_in   = crop_left_ff;
      crop_right_in  = crop_right_ff;
      crop_top_in    = crop_top_ff;
      crop_bottom_in = crop_bottom_ff;
      black_in       = black_ff;
      border_in      = border_ff;
      bg_in          = bg_ff;
      if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_CROP_LEFT:    crop_left_in   = csr_coord;
            CSR_CROP_RIGHT:   crop_right_in  = csr_coord;
            CSR_CROP_TOP:     crop_top_in    = csr_coord;
            CSR_CROP_BOTTOM:  crop_bottom_in = csr_coord;
            CSR_COLOR_BLACK:  black_in       = csr_data[COLOR_WIDTH-1:0];
            CSR_COLOR_BORDER: border_in      = csr_data[COLOR_WIDTH-1:0];
            CSR_COLOR_BG:     bg_in          = csr_data[COLOR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_left_ff   <= RW'(RESET_LEFT);
         crop_right_ff  <= RW'(RESET_RIGHT);
         crop_top_ff    <= RW'(RESET_TOP);
         crop_bottom_ff <= RW'(RESET_BOTTOM);
         black_ff       <= RESET_BLACK;
         border_ff      <= RESET_BORDER;
         bg_ff          <= RESET_BG;
      end else begin
         crop_left_ff   <= crop_left_in;
         crop_right_ff  <= crop_right_in;
         crop_top_ff    <= crop_top_in;
         crop_bottom_ff <= crop_bottom_in;
         black_ff       <= black_in;
         border_ff      <= border_in;
         bg_ff          <= bg_in;
      end
   end

   // ---------------- input register ----------------
   logic                   s1_valid_ff, s1_valid_in;
   logic [1:0]             s1_func_ff;
   logic [CW-1:0]          s1_x_ff, s1_y_ff;
   logic [PIXEL_WIDTH-1:0] s1_scr_ff, s1_mir_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [23:0]            rsp_data_ff, rsp_data_in;
   logic                   advance;
   logic                   req_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff <= req_tuser;
         s1_x_ff    <= req_tdata[CW-1:0];
         s1_y_ff    <= req_tdata[2*CW-1:CW];
         s1_scr_ff  <= req_tdata[2*CW+7:2*CW];
         s1_mir_ff  <= req_tdata[2*CW+15:2*CW+8];
      end
   end

   // ---------------- pixel logic ----------------
   logic signed [EW-1:0]   xe, ye, left_e, right_e, top_e, bottom_e;
   logic                   above, below, outside, band, far;
   logic [COLOR_WIDTH-1:0] color;
   logic [PIXEL_WIDTH-1:0] target;
   logic [PIXEL_WIDTH-1:0] s_out, m_out;
   logic                   s_we, m_we;

   assign xe       = signed'({{2{s1_x_ff[CW-1]}}, s1_x_ff});
   assign ye       = signed'({{2{s1_y_ff[CW-1]}}, s1_y_ff});
   assign left_e   = signed'({crop_left_ff[RW-1], crop_left_ff});
   assign right_e  = signed'({crop_right_ff[RW-1], crop_right_ff});
   assign top_e    = signed'({crop_top_ff[RW-1], crop_top_ff});
   assign bottom_e = signed'({crop_bottom_ff[RW-1], crop_bottom_ff});

   assign above   = ye < top_e;
   assign below   = ye > bottom_e;
   assign outside = above || below || (xe < left_e) || (xe > right_e);
   assign band    = (xe > left_e - TWO) && (xe < right_e + TWO) &&
                    (ye > top_e - TWO) && (ye < bottom_e + TWO);
   assign far     = (ye < top_e - TWO) || (ye > bottom_e + TWO);

   always_comb begin
      if (!outside) begin
         color = '0;
      end else if (band) begin
         color = border_ff;
      end else begin
         color = black_ff;
      end
      // a zero color leaves the mirror unflagged
      target = (color != '0) ? (MIRROR_FLAG | {1'b0, color}) : '0;
   end

   always_comb begin
      s_out = s1_scr_ff;
      s_we  = 1'b0;
      m_out = s1_mir_ff;
      m_we  = 1'b0;
      case (s1_func_ff)
         FUNC_MASK: begin
            if (target != s1_mir_ff) begin
               m_out = target;
               m_we  = 1'b1;
               // clear a stale cropmark pixel left on screen
               if (({1'b0, color} != s1_scr_ff) && s1_mir_ff[PIXEL_WIDTH-1] &&
                   ({1'b0, s1_mir_ff[PIXEL_WIDTH-2:0]} == s1_scr_ff)) begin
                  s_out = PIX_BLANK;
                  s_we  = 1'b1;
               end
            end
         end
         FUNC_DRAW: begin
            if (s1_mir_ff[PIXEL_WIDTH-1] &&
                (s1_scr_ff == PIX_BLANK || s1_scr_ff == PIX_GRAY ||
                 s1_scr_ff == PIX_DARK || s1_scr_ff == s1_mir_ff)) begin
               s_out = {1'b0, s1_mir_ff[PIXEL_WIDTH-2:0]};
               s_we  = 1'b1;
            end
         end
         FUNC_LETTERBOX: begin
            if ((above || below) && (s1_scr_ff == {1'b0, bg_ff})) begin
               s_out = far ? {1'b0, black_ff} : {1'b0, bg_ff};
               s_we  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = {6'd0, m_we, m_out, s_we, s_out};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_mirror_only_mask: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_func_ff != FUNC_MASK) |-> !m_we)
      else $error("mirror write outside mask function");

   a_mask_screen_clear: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_func_ff == FUNC_MASK) && s_we |-> m_we && (s_out == PIX_BLANK))
      else $error("mask function screen write is not a stale clear");

   a_pixel_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("pixel lost between input and result register");

   a_csr_left: assert property (@(posedge clock) disable iff (reset)
      csr_fire && (csr_index == CSR_CROP_LEFT) |=>
         crop_left_ff == $past(csr_coord))
      else $error("crop_left write not taken");

endmodule

`default_nettype wire

### test/overlay_cropmark_pixel_compositor_tb.sv
`timescale 1ns / 100ps

module overlay_cropmark_pixel_compositor_tb;
   import ocpc_pkg::*;

   localparam int CW = 11;
   localparam int DW = ((2 * CW + 16 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]    func;
      logic [7:0]    mir;
      logic [7:0]    scr;
      logic [CW-1:0] y;
      logic [CW-1:0] x;
   } pixel_type;

   // same bit order as rsp_tdata[17:0]
   typedef struct packed {
      logic       mirror_we;
      logic [7:0] mirror_out;
      logic       screen_we;
      logic [7:0] screen_out;
   } writeback_type;

   typedef struct {
      pixel_type     px;
      writeback_type wb;
   } pending_type;

   class writeback_scoreboard;
      int crop_left, crop_right, crop_top, crop_bottom;
      logic [6:0] black, border, bg;
      pending_type expected_writes[$];
      int mismatches, checked, screen_writes, mirror_writes;
      int func_seen[4];

      function new();
         crop_left   = RESET_LEFT;
         crop_right  = RESET_RIGHT;
         crop_top    = RESET_TOP;
         crop_bottom = RESET_BOTTOM;
         black  = RESET_BLACK;
         border = RESET_BORDER;
         bg     = RESET_BG;
      endfunction

      function void write_reg(logic [2:0] idx, logic [CW-1:0] data);
         case (idx)
            CSR_CROP_LEFT:    crop_left   = $signed(data);
            CSR_CROP_RIGHT:   crop_right  = $signed(data);
            CSR_CROP_TOP:     crop_top    = $signed(data);
            CSR_CROP_BOTTOM:  crop_bottom = $signed(data);
            CSR_COLOR_BLACK:  black  = data[6:0];
            CSR_COLOR_BORDER: border = data[6:0];
            CSR_COLOR_BG:     bg     = data[6:0];
            default: ;
         endcase
      endfunction

      function writeback_type composite_pixel(pixel_type p);
         writeback_type r;
         int x, y;
         logic [6:0] color;
         logic [7:0] target;
         bit outside, band, far;
         r.screen_out = p.scr;
         r.screen_we  = 1'b0;
         r.mirror_out = p.mir;
         r.mirror_we  = 1'b0;
         x = $signed(p.x);
         y = $signed(p.y);
         case (p.func)
            FUNC_MASK: begin
               outside = y < crop_top || y > crop_bottom || x < crop_left || x > crop_right;
               band = x > crop_left - 2 && x < crop_right + 2 &&
                      y > crop_top - 2 && y < crop_bottom + 2;
               color = outside ? (band ? border : black) : 7'd0;
               target = (color != 7'd0) ? (MIRROR_FLAG | {1'b0, color}) : 8'h00;
               if (target != p.mir) begin
                  // clear a stale cropmark pixel left on screen
                  if ({1'b0, color} != p.scr && (p.mir & MIRROR_FLAG) != 8'h00 &&
                      {1'b0, p.mir[6:0]} == p.scr) begin
                     r.screen_out = 8'h00;
                     r.screen_we  = 1'b1;
                  end
                  r.mirror_out = target;
                  r.mirror_we  = 1'b1;
               end
            end
            FUNC_DRAW: begin
               if ((p.mir & MIRROR_FLAG) != 8'h00 &&
                   (p.scr == PIX_BLANK || p.scr == PIX_GRAY || p.scr == PIX_DARK ||
                    p.scr == p.mir)) begin
                  r.screen_out = {1'b0, p.mir[6:0]};
                  r.screen_we  = 1'b1;
               end
            end
            FUNC_LETTERBOX: begin
               if ((y < crop_top || y > crop_bottom) && p.scr == {1'b0, bg}) begin
                  far = y < crop_top - 2 || y > crop_bottom + 2;
                  r.screen_out = far ? {1'b0, black} : {1'b0, bg};
                  r.screen_we  = 1'b1;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_pixel(pixel_type p);
         pending_type e;
         e.px = p;
         e.wb = composite_pixel(p);
         func_seen[p.func]++;
         expected_writes.push_back(e);
      endfunction

      function void check_result(writeback_type got);
         pending_type want;
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat %h at %0t", got, $realtime);
            return;
         end
         want = expected_writes.pop_front();
         checked++;
         screen_writes += want.wb.screen_we;
         mirror_writes += want.wb.mirror_we;
         if (got.screen_out !== want.wb.screen_out || got.screen_we !== want.wb.screen_we ||
             got.mirror_out !== want.wb.mirror_out || got.mirror_we !== want.wb.mirror_we) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch func %0d x %0d y %0d scr %h mir %h: ",
                         "exp %h/%b %h/%b, got %h/%b %h/%b"},
                        want.px.func, $signed(want.px.x), $signed(want.px.y), want.px.scr,
                        want.px.mir, want.wb.screen_out, want.wb.screen_we,
                        want.wb.mirror_out, want.wb.mirror_we, got.screen_out, got.screen_we,
                        got.mirror_out, got.mirror_we);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic [1:0]    req_tuser = 2'd0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [23:0]   rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;

   writeback_scoreboard board;
   int cycles = 0;
   int burst_left = 0;
   int stall_left = 0;
   logic [1:0] stall_mode = 2'd0;

   overlay_cropmark_pixel_compositor #(
      .COORD_WIDTH(CW)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("overlay_cropmark_pixel_compositor test failed");
         $finish;
      end
   end

   // watch all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            board.note_pixel(pixel_type'({req_tuser, req_tdata[2*CW+15:0]}));
         if (rsp_tvalid && rsp_tready)
            board.check_result(writeback_type'(rsp_tdata[17:0]));
      end
   end

   // receiver: switch between always ready, random, sparse and periodic stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= 1'(stall_left >> 2);
      endcase
   end

   task automatic write_reg(input logic [2:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CW-1:0];
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic write_setting(input int left, input int right, input int top,
                                input int bottom, input int blk, input int brd, input int bgc);
      write_reg(CSR_CROP_LEFT, left);
      write_reg(CSR_CROP_RIGHT, right);
      write_reg(CSR_CROP_TOP, top);
      write_reg(CSR_CROP_BOTTOM, bottom);
      write_reg(CSR_COLOR_BLACK, blk);
      write_reg(CSR_COLOR_BORDER, brd);
      write_reg(CSR_COLOR_BG, bgc);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [1:0] func, input int x, input int y,
                             input logic [7:0] scr, input logic [7:0] mir);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= DW'({mir, scr, y[CW-1:0], x[CW-1:0]});
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // aim at the crop edges two times in five so the border band gets hit
   function automatic int pick_coord(input int lo, input int hi);
      int v;
      case ($urandom_range(0, 4))
         0: v = lo - 3 + int'($urandom_range(0, 6));
         1: v = hi - 3 + int'($urandom_range(0, 6));
         2: v = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                           : hi + int'($urandom_range(0, lo - hi));
         default: v = int'($urandom_range(0, 2047)) - 1024;
      endcase
      return v;
   endfunction

   task automatic random_pixels(input int count);
      logic [1:0] func;
      logic [7:0] scr, mir;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 19);
         func = (pick == 0) ? FUNC_UNUSED : 2'(pick % 3);
         case ($urandom_range(0, 4))
            0: mir = 8'($urandom_range(0, 255));
            1: mir = 8'h00;
            2: mir = MIRROR_FLAG | {1'b0, board.black};
            3: mir = MIRROR_FLAG | {1'b0, board.border};
            default: mir = MIRROR_FLAG | 8'($urandom_range(0, 127));
         endcase
         case ($urandom_range(0, 8))
            0: scr = 8'($urandom_range(0, 255));
            1: scr = PIX_BLANK;
            2: scr = PIX_GRAY;
            3: scr = PIX_DARK;
            4: scr = mir;
            5: scr = mir & ~MIRROR_FLAG;
            6: scr = {1'b0, board.bg};
            7: scr = {1'b0, board.black};
            default: scr = {1'b0, board.border};
         endcase
         send_pixel(func, pick_coord(board.crop_left, board.crop_right),
                    pick_coord(board.crop_top, board.crop_bottom), scr, mir);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (board.expected_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int a, b, c, d, t;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 0..719 x 0..479, black 2, border 60, background 20
      send_pixel(FUNC_MASK, 100, 100, 8'h00, 8'h00);
      send_pixel(FUNC_MASK, 100, 100, 8'h3C, 8'hBC);  // stale cropmark cleared
      send_pixel(FUNC_MASK, 100, 100, 8'hBC, 8'hBC);
      send_pixel(FUNC_MASK, -1, 5, 8'h00, 8'h00);     // border band
      send_pixel(FUNC_MASK, 720, 480, 8'h55, 8'hD5);  // band corner, stale clear
      send_pixel(FUNC_MASK, -2, 5, 8'h11, 8'h82);     // just past the band
      send_pixel(FUNC_MASK, -1024, -1024, 8'hFF, 8'hFF);
      send_pixel(FUNC_MASK, 1023, 1023, 8'h00, 8'h80);
      send_pixel(FUNC_MASK, 721, 200, 8'h00, 8'h00);
      send_pixel(FUNC_DRAW, 5, 5, PIX_BLANK, 8'h85);
      send_pixel(FUNC_DRAW, 5, 5, PIX_GRAY, 8'hFF);
      send_pixel(FUNC_DRAW, 5, 5, PIX_DARK, 8'h81);
      send_pixel(FUNC_DRAW, 5, 5, 8'h9A, 8'h9A);
      send_pixel(FUNC_DRAW, 5, 5, 8'h20, 8'h85);
      send_pixel(FUNC_DRAW, 5, 5, PIX_BLANK, 8'h05);
      send_pixel(FUNC_LETTERBOX, 5, -1, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, -3, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, -2, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, 481, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, 482, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, 100, 8'h14, 8'h00);
      send_pixel(FUNC_LETTERBOX, 5, -5, 8'h15, 8'h00);
      send_pixel(FUNC_LETTERBOX, -1024, 1023, 8'h14, 8'hFF);
      send_pixel(FUNC_UNUSED, 1023, -1024, 8'hFF, 8'hFF);
      send_pixel(FUNC_UNUSED, 0, 0, 8'h14, 8'h80);
      random_pixels(RANDOM_PER_PHASE);
      drain();

      // small box round the origin, zero border color
      write_setting(-20, 20, -10, 10, 'h7FF, 0, 'h414);
      random_pixels(RANDOM_PER_PHASE);
      drain();

      // whole coordinate range visible
      write_setting(-1024, 1023, -1024, 1023, 0, 'h7F, 0);
      random_pixels(RANDOM_PER_PHASE);
      drain();

      // inverted rectangle: every pixel outside
      write_setting(1023, -1024, 1023, -1024, 1, 'h780, 'h7F);
      random_pixels(RANDOM_PER_PHASE);
      drain();

      // single-pixel rectangle in a corner of the range
      write_setting(-1024, -1024, 1023, 1023, 'h400, 'h3FF, 'h2AA);
      random_pixels(RANDOM_PER_PHASE);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         a = int'($urandom_range(0, 2047)) - 1024;
         b = int'($urandom_range(0, 2047)) - 1024;
         c = int'($urandom_range(0, 2047)) - 1024;
         d = int'($urandom_range(0, 2047)) - 1024;
         if (a > b && $urandom_range(0, 3) != 0) begin
            t = a;
            a = b;
            b = t;
         end
         if (c > d && $urandom_range(0, 3) != 0) begin
            t = c;
            c = d;
            d = t;
         end
         write_setting(a, b, c, d, $urandom_range(0, 2047), $urandom_range(0, 2047),
                       $urandom_range(0, 2047));
         random_pixels(RANDOM_PER_PHASE);
         drain();
      end

      $display("checked %0d pixels over 8 crop settings: %0d screen writes, %0d mirror writes",
               board.checked, board.screen_writes, board.mirror_writes);
      $display("mask %0d, draw %0d, letterbox %0d, unused code %0d; %0d mismatches",
               board.func_seen[0], board.func_seen[1], board.func_seen[2],
               board.func_seen[3], board.mismatches);
      if (board.mismatches == 0 && board.expected_writes.size() == 0)
         $display("overlay_cropmark_pixel_compositor test passed");
      else
         $display("overlay_cropmark_pixel_compositor test failed");
      $finish;
   end

endmodule
